/* rtl/ialu_pkg.sv */
// Package with the command codes and the command width of the ALU pipeline.
package ialu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MOD = 4'd4,
    CMD_AND = 4'd5,
    CMD_OR  = 4'd6,
    CMD_XOR = 4'd7,
    CMD_NOT = 4'd8,
    CMD_INC = 4'd9,
    CMD_EQ  = 4'd10,
    CMD_GT  = 4'd11,
    CMD_LT  = 4'd12
  } cmd_t;

  localparam int unsigned CMD_W = 4;

endpackage

/* rtl/ialu_cell.sv */
// One pipeline cell: a multiply step and a restoring divide step, each for one bit position.
module ialu_cell import ialu_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned STEP  = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] acc_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] rem_i,
  output logic             vld_o,
  output logic [CMD_W-1:0] cmd_o,
  output logic [WIDTH-1:0] a_o,
  output logic [WIDTH-1:0] b_o,
  output logic [WIDTH-1:0] acc_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] rem_o
);

  // Bit position handled here: multiply from the bottom, divide from the top.
  localparam int unsigned DBIT = WIDTH - 1 - STEP;

  logic             vld_r;
  logic [CMD_W-1:0] cmd_r;
  logic [WIDTH-1:0] a_r, b_r, acc_r, quo_r, rem_r;
  logic [WIDTH-1:0] acc_nxt, quo_nxt, rem_nxt, trial;
  logic             lost, skip;

  // Shift-and-add step for the multiply.
  always_comb begin
    acc_nxt = acc_i;
    if (b_i[STEP]) begin
      acc_nxt = acc_i + (a_i << STEP);
    end
  end

  // Restoring divide step; a zero divisor compares against all ones.
  always_comb begin
    if (DBIT == 0) begin
      lost = 1'b0;
    end else begin
      lost = ((b_i >> (WIDTH - DBIT)) != '0);
    end
    trial = (b_i == '0) ? '1 : (b_i << DBIT);
    skip  = (b_i != '0) && lost;
    quo_nxt = quo_i;
    rem_nxt = rem_i;
    if (!skip && (rem_i >= trial)) begin
      rem_nxt = rem_i - trial;
      quo_nxt[DBIT] = 1'b1;
    end
  end

  // Control bit is reset; the payload moves every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    cmd_r <= cmd_i;
    a_r   <= a_i;
    b_r   <= b_i;
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign vld_o = vld_r;
  assign cmd_o = cmd_r;
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign acc_o = acc_r;
  assign quo_o = quo_r;
  assign rem_o = rem_r;

endmodule

/* rtl/integer_alu_32bit.sv */
// Top level of the pipelined unsigned integer ALU.
//
//  channel  | ports                                  | direction
//  request  | start, busy, in_cmd, in_operand_a/b    | in (busy out)
//  result   | out_valid, out_result                  | out
//
// Each request passes from start to out_valid through one cell per bit of the
// multiply and divide, then one output register.
// A new request is accepted in every cycle; busy is held low.
// Reset is synchronous and clears the valid bits of the cells and the output.
// The receiver cannot stall; each result is shown for exactly one cycle.
module integer_alu_32bit import ialu_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_cmd,
  input  logic [WIDTH-1:0] in_operand_a,
  input  logic [WIDTH-1:0] in_operand_b,
  output logic             out_valid,
  output logic [31:0]      out_result
);

  logic             vld [WIDTH+1];
  logic [CMD_W-1:0] cmd [WIDTH+1];
  logic [WIDTH-1:0] a   [WIDTH+1];
  logic [WIDTH-1:0] b   [WIDTH+1];
  logic [WIDTH-1:0] acc [WIDTH+1];
  logic [WIDTH-1:0] quo [WIDTH+1];
  logic [WIDTH-1:0] rem [WIDTH+1];

  logic             out_valid_r;
  logic [WIDTH-1:0] res_nxt;
  logic [31:0]      out_result_r;

  assign busy = 1'b0;

  // Head of the chain.
  assign vld[0] = start;
  assign cmd[0] = in_cmd;
  assign a[0]   = in_operand_a;
  assign b[0]   = in_operand_b;
  assign acc[0] = '0;
  assign quo[0] = '0;
  assign rem[0] = in_operand_a;

  // Row of cells, one per bit.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    ialu_cell #(.WIDTH(WIDTH), .STEP(i)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(vld[i]), .cmd_i(cmd[i]), .a_i(a[i]), .b_i(b[i]),
      .acc_i(acc[i]), .quo_i(quo[i]), .rem_i(rem[i]),
      .vld_o(vld[i+1]), .cmd_o(cmd[i+1]), .a_o(a[i+1]), .b_o(b[i+1]),
      .acc_o(acc[i+1]), .quo_o(quo[i+1]), .rem_o(rem[i+1])
    );
  end

  // Final selection of the result by command.
  always_comb begin
    case (cmd[WIDTH])
      CMD_ADD: res_nxt = a[WIDTH] + b[WIDTH];
      CMD_SUB: res_nxt = a[WIDTH] - b[WIDTH];
      CMD_MUL: res_nxt = acc[WIDTH];
      CMD_DIV: res_nxt = quo[WIDTH];
      CMD_MOD: res_nxt = rem[WIDTH];
      CMD_AND: res_nxt = a[WIDTH] & b[WIDTH];
      CMD_OR:  res_nxt = a[WIDTH] | b[WIDTH];
      CMD_XOR: res_nxt = a[WIDTH] ^ b[WIDTH];
      CMD_NOT: res_nxt = ~a[WIDTH];
      CMD_INC: res_nxt = a[WIDTH] + WIDTH'(1);
      CMD_EQ:  res_nxt = WIDTH'(a[WIDTH] == b[WIDTH]);
      CMD_GT:  res_nxt = WIDTH'(a[WIDTH] > b[WIDTH]);
      CMD_LT:  res_nxt = WIDTH'(a[WIDTH] < b[WIDTH]);
      default: res_nxt = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[WIDTH];
    end
    out_result_r <= 32'(res_nxt);
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* rtl/ialu_checker.sv */
// Port-level checker for the ALU, bound to the top level.
module ialu_checker import ialu_pkg::*; #(
  parameter int unsigned LATENCY = 33
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [3:0]  in_cmd,
  input logic        out_valid,
  input logic [31:0] out_result
);

  // Never refuses a request.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Comparisons answer 0 or 1 after the full pipeline latency.
  a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_cmd == CMD_EQ || in_cmd == CMD_GT || in_cmd == CMD_LT))
    |-> ##LATENCY (out_valid && out_result[31:1] == 31'd0))
    else $error("comparison not boolean");

  // Unused command gives zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_cmd > CMD_LT) |-> ##LATENCY (out_valid && out_result == 32'd0))
    else $error("unused command nonzero");

  // Result appears exactly at the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("result missing");

endmodule

bind integer_alu_32bit ialu_checker #(.LATENCY(WIDTH + 1)) u_ialu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
  .out_valid(out_valid), .out_result(out_result)
);

/* tb/testbench.sv */
// Self-checking testbench for the pipelined unsigned integer ALU.
module testbench import ialu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned LATENCY = WIDTH + 1;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } alu_request_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [3:0]       in_cmd;
  logic [WIDTH-1:0] in_operand_a;
  logic [WIDTH-1:0] in_operand_b;
  logic             out_valid;
  logic [31:0]      out_result;

  alu_request_t     pending_requests[$];
  logic [31:0]      expected_results[$];
  int unsigned      mismatch_count;
  int unsigned      idle_cycles;
  int unsigned      send_idle_pct;
  bit               stimulus_done;
  bit               hold_sender;

  integer_alu_32bit #(.WIDTH(WIDTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Restoring divider that skips steps where the shifted divisor overflows.
  function automatic void restoring_divide(input logic [WIDTH-1:0] dividend,
                                           input logic [WIDTH-1:0] divisor,
                                           output logic [WIDTH-1:0] quotient,
                                           output logic [WIDTH-1:0] remainder);
    logic [WIDTH-1:0] trial;
    logic [2*WIDTH-1:0] wide_divisor;
    remainder = dividend;
    quotient = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (divisor == '0) begin
        trial = '1;
      end else begin
        wide_divisor = {{WIDTH{1'b0}}, divisor};
        if (i > 0 && (wide_divisor >> (WIDTH - i)) != 0) continue;
        trial = divisor << i;
      end
      if (remainder >= trial) begin
        remainder = remainder - trial;
        quotient[i] = 1'b1;
      end
    end
  endfunction

  // Expected result of one request.
  function automatic logic [31:0] alu_result(input alu_request_t req);
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] res;
    res = '0;
    case (req.cmd)
      CMD_ADD: res = req.a + req.b;
      CMD_SUB: res = req.a - req.b;
      CMD_MUL: res = req.a * req.b;
      CMD_DIV: begin
        restoring_divide(req.a, req.b, quo, rem);
        res = quo;
      end
      CMD_MOD: begin
        restoring_divide(req.a, req.b, quo, rem);
        res = rem;
      end
      CMD_AND: res = req.a & req.b;
      CMD_OR:  res = req.a | req.b;
      CMD_XOR: res = req.a ^ req.b;
      CMD_NOT: res = ~req.a;
      CMD_INC: res = req.a + 1'b1;
      CMD_EQ:  res = (req.a == req.b) ? 1 : 0;
      CMD_GT:  res = (req.a > req.b) ? 1 : 0;
      CMD_LT:  res = (req.a < req.b) ? 1 : 0;
      default: res = '0;
    endcase
    return res[31:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [WIDTH-1:0] random_operand();
    logic [WIDTH-1:0] value;
    case ($urandom_range(0, 5))
      0: value = '0;
      1: value = '1;
      2: value = WIDTH'($urandom_range(0, 15));
      3: value = WIDTH'($urandom) >> $urandom_range(0, WIDTH - 1);
      default: value = WIDTH'({$urandom, $urandom});
    endcase
    return value;
  endfunction

  task automatic queue_request(input logic [3:0] cmd, input logic [WIDTH-1:0] a,
                               input logic [WIDTH-1:0] b);
    alu_request_t req;
    req.cmd = cmd;
    req.a = a;
    req.b = b;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Driver: presents the next request at the falling edge and predicts it once accepted.
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      expected_results.insert(expected_results.size(),
                              alu_result(pending_requests.pop_front()));
    end
    if (rst_n && !hold_sender && pending_requests.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      start <= 1'b1;
      in_cmd <= pending_requests[0].cmd;
      in_operand_a <= pending_requests[0].a;
      in_operand_b <= pending_requests[0].b;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_result));
      end else begin
        want = expected_results.pop_front();
        if (out_result !== want)
          report_mismatch($sformatf("result %h, expected %h", out_result, want));
      end
    end
  end

  // Watchdog on cycles in which no request or result is accepted.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (!stimulus_done || expected_results.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] cmd;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stimulus_done = 1'b0;
    hold_sender = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: extremes, every command, unused codes, divide corner cases.
    hold_sender = 1'b1;
    for (int c = 0; c < 16; c++) queue_request(4'(c), '1, '1);
    queue_request(CMD_DIV, '1, '0);
    queue_request(CMD_MOD, '1, '0);
    queue_request(CMD_DIV, 32'h1234_5678, '0);
    queue_request(CMD_MOD, 32'h1234_5678, '0);
    queue_request(CMD_DIV, 32'hFFFF_FFFE, 32'h8000_0001);
    queue_request(CMD_MOD, 32'h0000_0007, 32'hC000_0000);
    queue_request(CMD_LT, 32'h5, 32'h5);
    queue_request(CMD_INC, '1, 32'hDEAD_BEEF);
    queue_request(CMD_ADD, '0, '0);
    hold_sender = 1'b0;

    // Random phases: sender idles 8%, then 67%, then never.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 67 : 0;
      for (int n = 0; n < 400; n++) begin
        cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                           : 4'($urandom_range(0, 12));
        queue_request(cmd, random_operand(), random_operand());
      end
      // Pause the sender until the pipeline has drained.
      wait (pending_requests.size() == 0);
      @(negedge clk);
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      @(negedge clk);
      hold_sender = 1'b0;
    end

    stimulus_done = 1'b1;
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* integer_alu_32bit.f */
rtl/ialu_pkg.sv
rtl/ialu_cell.sv
rtl/integer_alu_32bit.sv
rtl/ialu_checker.sv
tb/testbench.sv
